@@ rtl/kvsm_pkg.sv @@
// ----------------------------------------------------------------------------
// kvsm_pkg
// Types, constants and codes shared by the slot mapping block.
// ----------------------------------------------------------------------------
package kvsm_pkg;

  localparam int unsigned MAX_BATCH_DEF   = 64;
  localparam int unsigned MAX_COLUMNS_DEF = 64;
  localparam int unsigned MAX_TOKENS_DEF  = 1048576;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BATCH_COUNT   = 3'd0,
    REG_TABLE_COLUMNS = 3'd1,
    REG_LOGICAL_BS    = 3'd2,
    REG_PHYSICAL_BS   = 3'd3,
    REG_RATIO         = 3'd4,
    REG_COMPRESSED    = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    FUNC_WR_BOUNDARY = 2'd0,
    FUNC_WR_TABLE    = 2'd1,
    FUNC_LOOKUP      = 2'd2,
    FUNC_LENGTH      = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_LAST_RD,
    ST_LAST_CMP,
    ST_DIV1,
    ST_DIV2,
    ST_TBL_RD,
    ST_MUL,
    ST_LEN,
    ST_OUT
  } state_t;

  // Request to the shared divider.
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
    logic [15:0] rem;
  } div_rsp_t;

endpackage

@@ rtl/kvsm_if.sv @@
// ----------------------------------------------------------------------------
// kvsm_in_if / kvsm_out_if
// Valid/ready channels for lookup and write items and for results.
// ----------------------------------------------------------------------------
interface kvsm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [6:0]         boundary_index;
  logic [20:0]        boundary_value;
  logic [5:0]         table_row;
  logic [5:0]         table_column;
  logic signed [31:0] table_value;
  logic [19:0]        token_index;
  logic signed [63:0] token_position;
  logic signed [31:0] length_value;
  modport source (output valid, func, boundary_index, boundary_value, table_row,
                  table_column, table_value, token_index, token_position,
                  length_value, input ready);
  modport sink (input valid, func, boundary_index, boundary_value, table_row,
                table_column, table_value, token_index, token_position,
                length_value, output ready);
endinterface

interface kvsm_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] position_out;
  logic signed [6:0]  request;
  logic signed [63:0] slot;
  logic signed [31:0] length_quotient;
  logic [7:0]         length_remainder;
  modport source (output valid, position_out, request, slot, length_quotient,
                  length_remainder, input ready);
  modport sink (input valid, position_out, request, slot, length_quotient,
                length_remainder, output ready);
endinterface

@@ rtl/kvsm_div.sv @@
// ----------------------------------------------------------------------------
// kvsm_div
// Restoring divider, 64-bit dividend by 16-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module kvsm_div (
  input  logic               clk,
  input  logic               rst_n,
  input  kvsm_pkg::div_req_t req,
  output kvsm_pkg::div_rsp_t rsp
);

  logic [63:0] quot_r, quot_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] dvs_r, dvs_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [16:0] trial;

  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[15:0], quot_r[63]};
    if (req.start) begin
      quot_nxt = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = 7'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt  = trial - {1'b0, dvs_r};
        quot_nxt = {quot_r[62:0], 1'b1};
      end else begin
        rem_nxt  = trial;
        quot_nxt = {quot_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r[15:0];

endmodule

@@ rtl/kv_cache_slot_mapping_top.sv @@
// ----------------------------------------------------------------------------
// kv_cache_slot_mapping_top
// Paged KV-cache slot mapping: request search, page lookup and length split.
// ----------------------------------------------------------------------------
// Write items (func 0 and 1) give no result. A lookup runs a binary
// search over the boundaries, each step a memory read and a compare, up to
// ceil(log2(MAX_BATCH+1)) steps; a last read and compare then end the
// search and check the last boundary. Then come three passes through the
// shared bit-serial divider (position by logical block size, position plus
// one by the ratio for the group check, then the remainder by the ratio)
// and, if the page is kept and in range, a table read and a multiply;
// then the output load. A lookup with an invalid token or position skips
// the divider. A length item takes one divider pass. The divider gives one
// quotient bit a cycle. The block takes one item at a time; the result sits
// in an output register until taken, and a stalled output holds the next
// result back.
module kv_cache_slot_mapping_top #(
  parameter int unsigned MAX_BATCH   = kvsm_pkg::MAX_BATCH_DEF,
  parameter int unsigned MAX_COLUMNS = kvsm_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_TOKENS  = kvsm_pkg::MAX_TOKENS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [kvsm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kvsm_pkg::CFG_DATA_W-1:0]   cfg_data,
  kvsm_in_if.sink                           in_ch,
  kvsm_out_if.source                        out_ch
);

  localparam int unsigned BW  = $clog2(MAX_BATCH + 1);   // boundary address
  localparam int unsigned RW  = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
  localparam int unsigned CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned NBW = BW + 1;                  // search bounds

  // Config registers.
  logic [6:0]  batch_count_r;
  logic [6:0]  table_columns_r;
  logic [15:0] lbs_r;
  logic [15:0] pbs_r;
  logic [7:0]  ratio_r;
  logic        comp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batch_count_r   <= 7'd0;
      table_columns_r <= 7'd64;
      lbs_r           <= 16'd128;
      pbs_r           <= 16'd128;
      ratio_r         <= 8'd1;
      comp_r          <= 1'b0;
    end else if (cfg_we) begin
      unique case (kvsm_pkg::reg_idx_t'(cfg_index))
        kvsm_pkg::REG_BATCH_COUNT:   batch_count_r   <= cfg_data[6:0];
        kvsm_pkg::REG_TABLE_COLUMNS: table_columns_r <= cfg_data[6:0];
        kvsm_pkg::REG_LOGICAL_BS:    lbs_r           <= cfg_data;
        kvsm_pkg::REG_PHYSICAL_BS:   pbs_r           <= cfg_data;
        kvsm_pkg::REG_RATIO:         ratio_r         <= cfg_data[7:0];
        kvsm_pkg::REG_COMPRESSED:    comp_r          <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective divisors: zero acts as one.
  logic [15:0] lbs_eff, ratio_eff;
  assign lbs_eff   = (lbs_r == 16'd0) ? 16'd1 : lbs_r;
  assign ratio_eff = (ratio_r == 8'd0) ? 16'd1 : {8'd0, ratio_r};

  // Batch count clamped to MAX_BATCH.
  logic [NBW-1:0] nb;
  assign nb = ({25'd0, batch_count_r} > MAX_BATCH) ? NBW'(MAX_BATCH)
                                                   : NBW'(batch_count_r);

  // Memories.
  logic [20:0] bnd_mem [MAX_BATCH+1];
  logic [31:0] tbl_mem [MAX_BATCH*MAX_COLUMNS];
  logic [20:0] bnd_rd_r;
  logic [31:0] tbl_rd_r;
  logic [BW-1:0] bnd_raddr;
  logic [RW+CW-1:0] tbl_raddr;

  // Item latch.
  logic [1:0]  func_r;
  logic [6:0]  bidx_r;
  logic [20:0] bval_r;
  logic [5:0]  trow_r, tcol_r;
  logic [31:0] tval_r;
  logic [19:0] tok_r;
  logic [63:0] pos_r;
  logic [31:0] len_r;

  logic wr_bnd, wr_tbl;
  assign wr_bnd = (func_r == kvsm_pkg::FUNC_WR_BOUNDARY) &&
                  ({25'd0, bidx_r} <= MAX_BATCH);
  assign wr_tbl = (func_r == kvsm_pkg::FUNC_WR_TABLE) &&
                  ({26'd0, trow_r} < MAX_BATCH) && ({26'd0, tcol_r} < MAX_COLUMNS);

  kvsm_pkg::state_t st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (st_r == kvsm_pkg::ST_OUT && wr_bnd)
      bnd_mem[bidx_r[BW-1:0]] <= bval_r;
    if (st_r == kvsm_pkg::ST_OUT && wr_tbl)
      tbl_mem[(RW+CW)'(RW'(trow_r) * MAX_COLUMNS + CW'(tcol_r))] <= tval_r;
    bnd_rd_r <= bnd_mem[bnd_raddr];
    tbl_rd_r <= tbl_mem[tbl_raddr];
  end

  // Search and arithmetic state.
  logic [NBW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid;
  logic           valid_r, valid_nxt;
  logic [63:0]    page_r, page_nxt;
  logic [15:0]    prem_r, prem_nxt;
  logic [63:0]    slot_r, slot_nxt;
  logic           keep_r, keep_nxt;
  logic [31:0]    lq_r, lq_nxt;
  logic [7:0]     lr_r, lr_nxt;
  logic [46:0]    prod;

  assign mid = NBW'((lo_r + hi_r) >> 1);

  // Block number is non-negative when used, so 31 by 16 bits.
  assign prod = tbl_rd_r[30:0] * pbs_r;

  kvsm_pkg::div_req_t dreq;
  kvsm_pkg::div_rsp_t drsp;

  kvsm_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] o_pos_r, o_pos_nxt, o_slot_r, o_slot_nxt;
  logic [6:0]  o_req_r, o_req_nxt;
  logic [31:0] o_lq_r, o_lq_nxt;
  logic [7:0]  o_lr_r, o_lr_nxt;

  // Length split helpers: divide |v| then fix sign to floor.
  logic        len_neg;
  logic [63:0] len_mag;
  logic [31:0] lq_pos;
  logic [15:0] lr_pos;
  assign len_neg = len_r[31];
  assign len_mag = len_neg ? (64'd0 - {{32{len_r[31]}}, len_r}) : {32'd0, len_r};
  assign lq_pos  = drsp.quot[31:0];
  assign lr_pos  = drsp.rem;

  // Compressed-mode group check: a divider pass on pos+1 by the ratio, with
  // pos+1 wrapping at 2^64; the item maps when its remainder is zero.
  logic [1:0] dphase_r, dphase_nxt;

  assign in_ch.ready = (st_r == kvsm_pkg::ST_IDLE);

  always_comb begin
    st_nxt        = st_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    valid_nxt     = valid_r;
    page_nxt      = page_r;
    prem_nxt      = prem_r;
    slot_nxt      = slot_r;
    keep_nxt      = keep_r;
    lq_nxt        = lq_r;
    lr_nxt        = lr_r;
    dphase_nxt    = dphase_r;
    out_valid_nxt = out_valid_r;
    o_pos_nxt     = o_pos_r;
    o_slot_nxt    = o_slot_r;
    o_req_nxt     = o_req_r;
    o_lq_nxt      = o_lq_r;
    o_lr_nxt      = o_lr_r;
    dreq          = '0;
    bnd_raddr     = BW'(mid + NBW'(1));
    tbl_raddr     = (RW+CW)'(RW'(lo_r) * MAX_COLUMNS + CW'(page_r));

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    unique case (st_r)
      kvsm_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          lo_nxt = '0;
          hi_nxt = nb;
          slot_nxt = '1;
          unique case (kvsm_pkg::func_t'(in_ch.func))
            kvsm_pkg::FUNC_LOOKUP: st_nxt = kvsm_pkg::ST_SRCH_RD;
            kvsm_pkg::FUNC_LENGTH: st_nxt = kvsm_pkg::ST_LEN;
            default:               st_nxt = kvsm_pkg::ST_OUT;
          endcase
        end
      end
      kvsm_pkg::ST_SRCH_RD: begin
        if (nb == '0) st_nxt = kvsm_pkg::ST_OUT;
        else if (lo_r < hi_r) st_nxt = kvsm_pkg::ST_SRCH_CMP;
        else st_nxt = kvsm_pkg::ST_LAST_RD;
      end
      kvsm_pkg::ST_SRCH_CMP: begin
        if ({43'd0, bnd_rd_r} <= {44'd0, tok_r}) lo_nxt = mid + NBW'(1);
        else hi_nxt = mid;
        st_nxt = kvsm_pkg::ST_SRCH_RD;
      end
      kvsm_pkg::ST_LAST_RD: begin
        bnd_raddr = BW'(nb);
        st_nxt    = kvsm_pkg::ST_LAST_CMP;
      end
      kvsm_pkg::ST_LAST_CMP: begin
        valid_nxt = ({1'b0, tok_r} < bnd_rd_r) && !pos_r[63] &&
                    ({44'd0, tok_r} < 64'(MAX_TOKENS));
        if (({1'b0, tok_r} < bnd_rd_r) && !pos_r[63] &&
            ({44'd0, tok_r} < 64'(MAX_TOKENS))) begin
          dreq.start    = 1'b1;
          dreq.dividend = pos_r;
          dreq.divisor  = lbs_eff;
          dphase_nxt    = 2'd0;
          st_nxt        = kvsm_pkg::ST_DIV1;
        end else begin
          st_nxt = kvsm_pkg::ST_OUT;
        end
      end
      kvsm_pkg::ST_DIV1: begin
        if (drsp.done) begin
          if (dphase_r == 2'd0) begin
            page_nxt      = drsp.quot;
            prem_nxt      = drsp.rem;
            dreq.start    = 1'b1;
            dreq.dividend = pos_r + 64'd1;
            dreq.divisor  = ratio_eff;
            dphase_nxt    = 2'd1;
          end else begin
            keep_nxt      = !comp_r || (drsp.rem == 16'd0);
            dreq.start    = 1'b1;
            dreq.dividend = {48'd0, prem_r};
            dreq.divisor  = ratio_eff;
            st_nxt        = kvsm_pkg::ST_DIV2;
          end
        end
      end
      kvsm_pkg::ST_DIV2: begin
        if (drsp.done) begin
          prem_nxt = drsp.quot[15:0];
          if (keep_r && (page_r < {57'd0, table_columns_r}) &&
              (page_r < 64'(MAX_COLUMNS)) && (lo_r < nb))
            st_nxt = kvsm_pkg::ST_TBL_RD;
          else
            st_nxt = kvsm_pkg::ST_OUT;
        end
      end
      kvsm_pkg::ST_TBL_RD: st_nxt = kvsm_pkg::ST_MUL;
      kvsm_pkg::ST_MUL: begin
        if (!tbl_rd_r[31])
          slot_nxt = {17'd0, prod} + {48'd0, prem_r};
        st_nxt = kvsm_pkg::ST_OUT;
      end
      kvsm_pkg::ST_LEN: begin
        if (dphase_r != 2'd3) begin
          dreq.start    = 1'b1;
          dreq.dividend = len_mag;
          dreq.divisor  = ratio_eff;
          dphase_nxt    = 2'd3;
        end else if (drsp.done) begin
          dphase_nxt = 2'd0;
          if (len_neg && lr_pos != 16'd0) begin
            lq_nxt = 32'd0 - lq_pos - 32'd1;
            lr_nxt = 8'(ratio_eff - lr_pos);
          end else if (len_neg) begin
            lq_nxt = 32'd0 - lq_pos;
            lr_nxt = 8'd0;
          end else begin
            lq_nxt = lq_pos;
            lr_nxt = lr_pos[7:0];
          end
          st_nxt = kvsm_pkg::ST_OUT;
        end
      end
      kvsm_pkg::ST_OUT: begin
        if (func_r == kvsm_pkg::FUNC_WR_BOUNDARY || func_r == kvsm_pkg::FUNC_WR_TABLE) begin
          st_nxt = kvsm_pkg::ST_IDLE;
        end else if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          if (func_r == kvsm_pkg::FUNC_LOOKUP) begin
            o_pos_nxt  = pos_r;
            o_lq_nxt   = '0;
            o_lr_nxt   = '0;
            if (nb == '0) begin
              o_req_nxt  = 7'd0;
              o_slot_nxt = '1;
            end else begin
              o_req_nxt  = valid_r ? 7'(lo_r) : 7'h7F;
              o_slot_nxt = valid_r ? slot_r : '1;
            end
          end else begin
            o_pos_nxt  = '0;
            o_req_nxt  = '0;
            o_slot_nxt = '0;
            o_lq_nxt   = lq_r;
            o_lr_nxt   = lr_r;
          end
          st_nxt = kvsm_pkg::ST_IDLE;
        end
      end
      default: st_nxt = kvsm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= kvsm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      dphase_r    <= 2'd0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      dphase_r    <= dphase_nxt;
    end
    if (in_ch.valid && in_ch.ready) begin
      func_r <= in_ch.func;
      bidx_r <= in_ch.boundary_index;
      bval_r <= in_ch.boundary_value;
      trow_r <= in_ch.table_row;
      tcol_r <= in_ch.table_column;
      tval_r <= in_ch.table_value;
      tok_r  <= in_ch.token_index;
      pos_r  <= in_ch.token_position;
      len_r  <= in_ch.length_value;
    end
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    valid_r  <= valid_nxt;
    page_r   <= page_nxt;
    prem_r   <= prem_nxt;
    slot_r   <= slot_nxt;
    keep_r   <= keep_nxt;
    lq_r     <= lq_nxt;
    lr_r     <= lr_nxt;
    o_pos_r  <= o_pos_nxt;
    o_slot_r <= o_slot_nxt;
    o_req_r  <= o_req_nxt;
    o_lq_r   <= o_lq_nxt;
    o_lr_r   <= o_lr_nxt;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.position_out     = o_pos_r;
  assign out_ch.request          = o_req_r;
  assign out_ch.slot             = o_slot_r;
  assign out_ch.length_quotient  = o_lq_r;
  assign out_ch.length_remainder = o_lr_r;

endmodule

@@ test/kv_cache_slot_mapping_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kv_cache_slot_mapping_top_tb
// Self-checking bench for the slot mapping block. Boundaries are loaded in
// full first and a table entry is written before the first lookup that reads
// it; then each register setting runs random lookup, length and write
// items, the first setting directed ones as well. Results are predicted in
// the bench and compared field by field, in order.
// ----------------------------------------------------------------------------
module kv_cache_slot_mapping_top_tb;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned SETTLE      = 400;   // exceeds the worst lookup latency
  localparam int unsigned NUM_REQ     = 64;
  localparam int unsigned NUM_COLS    = 64;

  // One input item as driven on the channel
  typedef struct {
    kvsm_pkg::func_t    func;
    logic [6:0]         bidx;
    logic [20:0]        bval;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] tval;
    logic [19:0]        tok;
    logic signed [63:0] pos;
    logic signed [31:0] len;
  } job_t;

  // One result item
  typedef struct {
    logic signed [63:0] pos;
    logic signed [6:0]  req;
    logic signed [63:0] slot;
    logic signed [31:0] quot;
    logic [7:0]         rem;
  } mapping_t;

  // One register setting
  typedef struct {
    logic [6:0]  batch;
    logic [6:0]  cols;
    logic [15:0] lbs;
    logic [15:0] pbs;
    logic [7:0]  ratio;
    logic        comp;
  } setting_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [kvsm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [kvsm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  kvsm_in_if  in_ch();
  kvsm_out_if out_ch();

  kv_cache_slot_mapping_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  always #2 clk = ~clk;

  // Predictor state: a copy of the stores and registers
  logic [20:0]        bnd_model [0:NUM_REQ];
  logic signed [31:0] tbl_model [0:NUM_REQ-1][0:NUM_COLS-1];
  logic [6:0]         cfg_batch = 7'd0;
  logic [6:0]         cfg_cols  = 7'd64;
  logic [15:0]        cfg_lbs   = 16'd128;
  logic [15:0]        cfg_pbs   = 16'd128;
  logic [7:0]         cfg_ratio = 8'd1;
  logic               cfg_comp  = 1'b0;

  // Generator's view of the boundaries and of the written table entries,
  // kept in queue order
  logic [20:0]        gen_bnd [0:NUM_REQ];
  bit                 gen_tbl_set [0:NUM_REQ-1][0:NUM_COLS-1];

  job_t     pending_jobs[$];
  mapping_t expected_maps[$];
  int unsigned jobs_queued = 0;
  int unsigned jobs_taken  = 0;
  int unsigned failures    = 0;
  int unsigned cycles      = 0;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic mapping_t map_token(job_t j);
    mapping_t    res;
    logic [63:0] posu;
    logic [63:0] lbs, rr, page;
    int          nb, lo, hi, mid;
    bit          ok, keep;
    logic signed [31:0] phys;
    posu = j.pos;
    res = '{default: '0};
    res.pos  = j.pos;
    res.slot = '1;
    nb = (cfg_batch > NUM_REQ) ? NUM_REQ : int'(cfg_batch);
    if (nb != 0) begin
      lo = 0;
      hi = nb;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (bnd_model[mid+1] <= j.tok) lo = mid + 1;
        else hi = mid;
      end
      ok = (j.tok < bnd_model[nb]) && !posu[63];
      res.req = ok ? 7'(lo) : 7'h7F;
      if (ok) begin
        lbs  = (cfg_lbs == 0) ? 64'd1 : 64'(cfg_lbs);
        rr   = (cfg_ratio == 0) ? 64'd1 : 64'(cfg_ratio);
        page = posu / lbs;
        // posu+1 wraps at 2^64 on purpose
        keep = !cfg_comp || (((posu + 64'd1) % rr) == 0);
        if (keep && page < cfg_cols && page < NUM_COLS && lo < nb) begin
          phys = tbl_model[lo][page[5:0]];
          if (phys >= 0)
            res.slot = {32'd0, phys} * {48'd0, cfg_pbs} + (posu % lbs) / rr;
        end
      end
    end
    return res;
  endfunction

  function automatic mapping_t split_length(job_t j);
    mapping_t           res;
    logic signed [63:0] v, rs, q, m;
    res = '{default: '0};
    v  = j.len;
    rs = (cfg_ratio == 0) ? 64'sd1 : signed'({56'd0, cfg_ratio});
    q  = v / rs;
    m  = v % rs;
    if (m < 0) begin
      m = m + rs;
      q = q - 1;
    end
    res.quot = q[31:0];
    res.rem  = m[7:0];
    return res;
  endfunction

  // Applies one accepted item to the model, queueing any result
  task automatic absorb_job(job_t j);
    case (j.func)
      kvsm_pkg::FUNC_WR_BOUNDARY: if (j.bidx <= NUM_REQ) bnd_model[j.bidx] = j.bval;
      kvsm_pkg::FUNC_WR_TABLE:    tbl_model[j.row][j.col] = j.tval;
      kvsm_pkg::FUNC_LOOKUP:      expected_maps.push_back(map_token(j));
      default:                    expected_maps.push_back(split_length(j));
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Driver: bursts of random length, random gaps between them
  // --------------------------------------------------------------------------
  job_t cur_job;
  int   burst_left = 0;
  int   gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        absorb_job(cur_job);
        jobs_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_jobs.size() > 0) begin
          cur_job = pending_jobs.pop_front();
          in_ch.valid          <= 1'b1;
          in_ch.func           <= cur_job.func;
          in_ch.boundary_index <= cur_job.bidx;
          in_ch.boundary_value <= cur_job.bval;
          in_ch.table_row      <= cur_job.row;
          in_ch.table_column   <= cur_job.col;
          in_ch.table_value    <= cur_job.tval;
          in_ch.token_index    <= cur_job.tok;
          in_ch.token_position <= cur_job.pos;
          in_ch.length_value   <= cur_job.len;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            // a third of the gaps are empty, giving long unbroken runs
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: receiver stalls on a rotating pattern, compares in order
  // --------------------------------------------------------------------------
  logic [15:0] stall_pat = 16'h0;
  mapping_t    exp_map;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_maps.size() == 0) begin
          $error("result item with nothing expected");
          failures++;
        end else begin
          exp_map = expected_maps.pop_front();
          if (out_ch.position_out !== exp_map.pos) begin
            $error("position_out: expected %0d, got %0d", exp_map.pos, out_ch.position_out);
            failures++;
          end
          if (out_ch.request !== exp_map.req) begin
            $error("request: expected %0d, got %0d", exp_map.req, out_ch.request);
            failures++;
          end
          if (out_ch.slot !== exp_map.slot) begin
            $error("slot: expected %0d, got %0d", exp_map.slot, out_ch.slot);
            failures++;
          end
          if (out_ch.length_quotient !== exp_map.quot) begin
            $error("length_quotient: expected %0d, got %0d", exp_map.quot,
                   out_ch.length_quotient);
            failures++;
          end
          if (out_ch.length_remainder !== exp_map.rem) begin
            $error("length_remainder: expected %0d, got %0d", exp_map.rem,
                   out_ch.length_remainder);
            failures++;
          end
        end
      end
      // new pattern now and then; all-zero pattern means no stalls
      if ($urandom_range(0, 63) == 0)
        stall_pat = ($urandom_range(0, 2) == 0) ? 16'h0 : 16'($urandom);
      stall_pat = {stall_pat[14:0], stall_pat[15]};
      out_ch.ready <= !stall_pat[0];
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic job_t rand_job(kvsm_pkg::func_t f);
    job_t j;
    j.func = f;
    j.bidx = 7'($urandom);
    j.bval = 21'($urandom);
    j.row  = 6'($urandom);
    j.col  = 6'($urandom);
    j.tval = $urandom;
    j.tok  = 20'($urandom);
    j.pos  = {$urandom, $urandom};
    j.len  = $urandom;
    return j;
  endfunction

  task automatic add_job(job_t j);
    if (j.func == kvsm_pkg::FUNC_WR_BOUNDARY && j.bidx <= NUM_REQ) gen_bnd[j.bidx] = j.bval;
    if (j.func == kvsm_pkg::FUNC_WR_TABLE) gen_tbl_set[j.row][j.col] = 1'b1;
    pending_jobs.push_back(j);
    jobs_queued++;
  endtask

  // Queues a lookup, first writing the table entry it reads if it has none
  task automatic add_lookup(logic [19:0] tok, logic signed [63:0] pos);
    job_t        j;
    job_t        w;
    logic [63:0] posu, lbs, rr, page;
    int          nb, lo, hi, mid;
    bit          keep;
    posu = pos;
    nb = (cfg_batch > NUM_REQ) ? NUM_REQ : int'(cfg_batch);
    lo = 0;
    hi = nb;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (gen_bnd[mid+1] <= tok) lo = mid + 1;
      else hi = mid;
    end
    lbs  = (cfg_lbs == 0) ? 64'd1 : 64'(cfg_lbs);
    rr   = (cfg_ratio == 0) ? 64'd1 : 64'(cfg_ratio);
    page = posu / lbs;
    keep = !cfg_comp || (((posu + 64'd1) % rr) == 0);
    if (nb != 0 && tok < gen_bnd[nb] && !posu[63] && keep && page < cfg_cols &&
        page < NUM_COLS && lo < nb && !gen_tbl_set[lo][page[5:0]]) begin
      w = rand_job(kvsm_pkg::FUNC_WR_TABLE);
      w.row = 6'(lo);
      w.col = page[5:0];
      if ($urandom_range(0, 7) != 0) w.tval = $urandom_range(0, 5000);
      add_job(w);
    end
    j = rand_job(kvsm_pkg::FUNC_LOOKUP);
    j.tok = tok;
    j.pos = pos;
    add_job(j);
  endtask

  task automatic add_length(logic signed [31:0] len);
    job_t j;
    j = rand_job(kvsm_pkg::FUNC_LENGTH);
    j.len = len;
    add_job(j);
  endtask

  // Waits for every item taken and every result in, then lets the block settle
  task automatic drain();
    while (jobs_taken != jobs_queued || expected_maps.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(kvsm_pkg::reg_idx_t idx, logic [15:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    case (idx)
      kvsm_pkg::REG_BATCH_COUNT:   cfg_batch = v[6:0];
      kvsm_pkg::REG_TABLE_COLUMNS: cfg_cols  = v[6:0];
      kvsm_pkg::REG_LOGICAL_BS:    cfg_lbs   = v;
      kvsm_pkg::REG_PHYSICAL_BS:   cfg_pbs   = v;
      kvsm_pkg::REG_RATIO:         cfg_ratio = v[7:0];
      default:                     cfg_comp  = v[0];
    endcase
  endtask

  task automatic apply_setting(setting_t s);
    write_reg(kvsm_pkg::REG_BATCH_COUNT,   16'(s.batch));
    write_reg(kvsm_pkg::REG_TABLE_COLUMNS, 16'(s.cols));
    write_reg(kvsm_pkg::REG_LOGICAL_BS,    s.lbs);
    write_reg(kvsm_pkg::REG_PHYSICAL_BS,   s.pbs);
    write_reg(kvsm_pkg::REG_RATIO,         16'(s.ratio));
    write_reg(kvsm_pkg::REG_COMPRESSED,    16'(s.comp));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Picks a position: mostly inside the mapped pages, with edges and noise
  function automatic logic signed [63:0] pick_pos();
    logic [63:0] lbs, rr, span, p;
    int unsigned cols;
    lbs  = (cfg_lbs == 0) ? 64'd1 : 64'(cfg_lbs);
    rr   = (cfg_ratio == 0) ? 64'd1 : 64'(cfg_ratio);
    cols = (cfg_cols > NUM_COLS) ? NUM_COLS : cfg_cols;
    span = lbs * (cols + 1);
    case ($urandom_range(0, 9))
      0: p = {1'b1, 31'($urandom), $urandom};
      1: p = {$urandom, $urandom};
      2: begin
        case ($urandom_range(0, 3))
          0: p = 64'h7FFF_FFFF_FFFF_FFFF;
          1: p = 64'h8000_0000_0000_0000;
          2: p = '1;
          default: p = 64'd0;
        endcase
      end
      default: begin
        p = 64'($urandom_range(0, int'(span[31:0]) - 1));
        // in compressed mode mostly hit the end of a group
        if (cfg_comp && $urandom_range(0, 2) != 0) p = (p / rr) * rr + rr - 1;
      end
    endcase
    return p;
  endfunction

  function automatic logic [19:0] pick_tok();
    int unsigned nb;
    int unsigned top;
    nb  = (cfg_batch > NUM_REQ) ? NUM_REQ : cfg_batch;
    top = gen_bnd[nb] + 4;
    if ($urandom_range(0, 15) == 0 || top > 20'hFFFFF) return 20'($urandom);
    return 20'($urandom_range(0, top));
  endfunction

  task automatic add_random_jobs(int unsigned n);
    job_t        j;
    int unsigned i, k, lo_v, hi_v;
    for (i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 8) begin
        // boundary rewrite that keeps the sequence mostly ascending
        j = rand_job(kvsm_pkg::FUNC_WR_BOUNDARY);
        j.bidx = 7'($urandom_range(1, NUM_REQ - 1));
        lo_v = gen_bnd[j.bidx - 1];
        hi_v = gen_bnd[j.bidx + 1];
        if (hi_v >= lo_v) j.bval = 21'($urandom_range(lo_v, hi_v));
        add_job(j);
      end else if (k < 10) begin
        j = rand_job(kvsm_pkg::FUNC_WR_BOUNDARY);
        j.bidx = 7'($urandom_range(NUM_REQ + 1, 127));   // ignored by the block
        add_job(j);
      end else if (k < 20) begin
        j = rand_job(kvsm_pkg::FUNC_WR_TABLE);
        if ($urandom_range(0, 3) != 0) j.tval = $urandom_range(0, 5000);
        add_job(j);
      end else if (k < 78) begin
        add_lookup(pick_tok(), pick_pos());
      end else begin
        add_length($urandom_range(0, 3) == 0 ? 32'($urandom_range(0, 600)) - 300
                                             : 32'($urandom));
      end
    end
  endtask

  setting_t    settings [0:5];
  job_t        j;
  int unsigned p, r, acc;

  initial begin
    // idle values on every input from time zero
    in_ch.valid = 1'b0;
    in_ch.func = kvsm_pkg::FUNC_WR_BOUNDARY;
    in_ch.boundary_index = '0;
    in_ch.boundary_value = '0;
    in_ch.table_row = '0;
    in_ch.table_column = '0;
    in_ch.table_value = '0;
    in_ch.token_index = '0;
    in_ch.token_position = '0;
    in_ch.length_value = '0;
    out_ch.ready = 1'b0;

    //                batch   cols    lbs       pbs       ratio  comp
    settings[0] = '{7'd4,   7'd64,  16'd16,    16'd128,   8'd1,   1'b0};
    settings[1] = '{7'd64,  7'd64,  16'd1,     16'd65535, 8'd255, 1'b1};
    settings[2] = '{7'd0,   7'd1,   16'd65535, 16'd1,     8'd0,   1'b0};
    settings[3] = '{7'd127, 7'd127, 16'd0,     16'd0,     8'd3,   1'b1};
    settings[4] = '{7'd17,  7'd0,   16'd4,     16'd64,    8'd4,   1'b1};
    settings[5] = '{7'd40,  7'd32,  16'd8,     16'd16,    8'd1,   1'b0};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Load every boundary so no search reads an unwritten one.
    // Boundaries rise in random steps, zero-length requests included.
    acc = 0;
    for (r = 0; r <= NUM_REQ; r++) begin
      j = rand_job(kvsm_pkg::FUNC_WR_BOUNDARY);
      j.bidx = 7'(r);
      j.bval = 21'(acc);
      add_job(j);
      acc += ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 40);
    end
    drain();

    for (p = 0; p < 6; p++) begin
      apply_setting(settings[p]);
      if (p == 0) begin
        // directed: edges of the fields and the special cases
        add_lookup(20'd0, 64'sd0);
        add_lookup(20'(gen_bnd[4] - 1), 64'sd17);
        add_lookup(20'(gen_bnd[4]), 64'sd3);            // at the last boundary
        add_lookup(20'hFFFFF, 64'sd5);                  // largest token
        add_lookup(20'd1, -64'sd1);                     // negative position
        add_lookup(20'd1, 64'sh8000_0000_0000_0000);
        add_lookup(20'd1, 64'sh7FFF_FFFF_FFFF_FFFF);
        add_lookup(20'd1, 64'sd1024);                   // page past the row
        add_lookup(20'd1, 64'sd1023);                   // last page of the row
        add_length(32'sd0);
        add_length(-32'sd1);
        add_length(32'sh7FFF_FFFF);
        add_length(32'sh8000_0000);
        add_length(32'sd7);
        // ignored writes, widest index and value
        j = rand_job(kvsm_pkg::FUNC_WR_BOUNDARY);
        j.bidx = 7'd127;
        j.bval = 21'h1F_FFFF;
        add_job(j);
        j.bidx = 7'd65;
        add_job(j);
        // unmapped entry and extreme table values on the corner row
        j = rand_job(kvsm_pkg::FUNC_WR_TABLE);
        j.row = 6'd0;
        j.col = 6'd0;
        j.tval = 32'sh8000_0000;
        add_job(j);
        add_lookup(20'd0, 64'sd2);
        j.tval = 32'sh7FFF_FFFF;
        add_job(j);
        add_lookup(20'd0, 64'sd15);
        j.row = 6'd63;
        j.col = 6'd63;
        j.tval = 32'sd9;
        add_job(j);
      end
      // the sender waits here for every result before the next half
      add_random_jobs(50);
      drain();
      add_random_jobs(50);
      drain();
    end

    if (failures == 0 && expected_maps.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (expected_maps.size() != 0)
        $error("%0d expected results never arrived", expected_maps.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/kvsm_pkg.sv
rtl/kvsm_if.sv
rtl/kvsm_div.sv
rtl/kv_cache_slot_mapping_top.sv
test/kv_cache_slot_mapping_top_tb.sv
